FILE: hdl/pet_pkg.sv
package pet_pkg;

  localparam int CoordW = 16;
  localparam int TimeW  = 32;
  localparam int OpW    = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam int MulW = 32;
  localparam int NumW = 50;
  localparam int DenW = 23;

  localparam logic [OpW-1:0] OP_DOWN    = 3'd0;
  localparam logic [OpW-1:0] OP_UP      = 3'd1;
  localparam logic [OpW-1:0] OP_MOVE    = 3'd2;
  localparam logic [OpW-1:0] OP_GESTURE = 3'd3;

  localparam logic [CfgIdxW-1:0] REG_TAP_RADIUS     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TAP_RADIUS_MIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SHRINK_PERIOD  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHRINK_PERCENT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_MOVE_RATE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_GEST_RATE  = 3'd5;

  localparam logic [9:0] RATE_SCALE    = 10'd1000;
  localparam logic [6:0] PERCENT_SCALE = 7'd100;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

endpackage

FILE: hdl/pet_mul.sv
module pet_mul (
  input  logic                         clk,
  input  logic [pet_pkg::MulW-1:0]     a,
  input  logic [pet_pkg::MulW-1:0]     b,
  output logic [2*pet_pkg::MulW-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hdl/pet_div.sv
module pet_div (
  input  logic              clk,
  input  logic              rst,
  input  pet_pkg::div_req_t req,
  output pet_pkg::div_rsp_t rsp
);

  localparam int NumW = pet_pkg::NumW;
  localparam int DenW = pet_pkg::DenW;
  localparam int CntW = $clog2(NumW);

  logic            busy;
  logic            done;
  logic [CntW-1:0] count;
  logic [NumW-1:0] quo;
  logic [DenW-1:0] rem;
  logic [DenW-1:0] den;
  logic [DenW:0]   rem_sh;
  logic [DenW:0]   rem_diff;
  logic            ge;
  logic [DenW-1:0] rem_next;

  assign rem_sh   = {rem, quo[NumW-1]};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_diff = rem_sh - {1'b0, den};
  assign rem_next = ge ? rem_diff[DenW-1:0] : rem_sh[DenW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == CntW'(NumW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      count <= '0;
      quo   <= req.num;
      rem   <= '0;
      den   <= req.den;
    end else if (busy) begin
      count <= count + 1'b1;
      quo   <= {quo[NumW-2:0], ge};
      rem   <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

FILE: hdl/pen_event_throttle_core.sv
// Channel  Dir  Transfer when            Payload
// s_*      in   s_tvalid & s_tready      tdata: pos_x, pos_y, time_ms; tuser: operation
// m_*      out  m_tvalid & m_tready      tdata: out_x, out_y; tuser: drop
// cfg_*    in   cfg_valid & cfg_ready    cfg_index, cfg_data
//
// One event is worked on at a time; s_tready is high only in the idle state.
// Pen down, pen up and other events go from decode to output; rate-checked moves and
// gestures add a rate multiply and compare; a tracked move squares radius, dx, dy and
// compares; on a long touch the 50-step restoring divider first computes radius shrink.
// A finished result waits in the output register; the next event is accepted meanwhile.
// Reset is synchronous and loads the register defaults and the initial pen state.
module pen_event_throttle_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pos_x, pos_y, time_ms
  input  logic [2:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_x, out_y
  output logic        m_tuser,   // drop
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int MulW = pet_pkg::MulW;
  localparam int NumW = pet_pkg::NumW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RATE  = 4'd2;
  localparam logic [3:0] S_RCMP  = 4'd3;
  localparam logic [3:0] S_RP    = 4'd4;
  localparam logic [3:0] S_NUM   = 4'd5;
  localparam logic [3:0] S_DEN   = 4'd6;
  localparam logic [3:0] S_DIVGO = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_R2    = 4'd9;
  localparam logic [3:0] S_DX    = 4'd10;
  localparam logic [3:0] S_DY    = 4'd11;
  localparam logic [3:0] S_CMP   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;

  logic [11:0] tap_radius;
  logic [11:0] tap_radius_min;
  logic [15:0] shrink_period_ms;
  logic [6:0]  shrink_percent;
  logic [9:0]  max_move_rate_hz;
  logic [9:0]  max_gesture_rate_hz;

  logic        tap_tracking;
  logic [15:0] last_move_x;
  logic [15:0] last_move_y;
  logic [31:0] last_move_time;
  logic [31:0] last_down_time;
  logic [15:0] last_gesture_x;
  logic [15:0] last_gesture_y;
  logic [31:0] last_gesture_time;

  logic [2:0]  op;
  logic [15:0] x;
  logic [15:0] y;
  logic [31:0] t;

  logic            drop;
  logic [11:0]     radius;
  logic [NumW-1:0] num;
  logic [23:0]     radius_sq;
  logic [31:0]     dx_sq;

  logic            out_drop;
  logic [15:0]     out_x;
  logic [15:0]     out_y;

  logic [MulW-1:0]   mul_a;
  logic [MulW-1:0]   mul_b;
  logic [2*MulW-1:0] mul_p;

  pet_pkg::div_req_t div_req;
  pet_pkg::div_rsp_t div_rsp;

  logic [31:0] delta_move;
  logic [31:0] delta_gest;
  logic [31:0] touch;
  logic [31:0] delta_sel;
  logic [10:0] rate_lim;
  logic        touch_long;
  logic [15:0] period_eff;
  logic [15:0] mag_dx;
  logic [15:0] mag_dy;
  logic        gest_near;
  logic        same_pos;
  logic        move_rate_hit;
  logic        gest_rate_hit;
  logic [11:0] rad_diff;
  logic [11:0] radius_shrunk;
  logic [32:0] dist_sq;
  logic        out_free;

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    logic signed [16:0] d;
    logic [16:0]        m;
    d = $signed({a[15], a}) - $signed({b[15], b});
    m = d[16] ? 17'(-d) : 17'(d);
    return m[15:0];
  endfunction

  function automatic logic rate_hit(input logic [31:0] d);
    return !d[31] && d != 32'd0 && d <= {22'd0, pet_pkg::RATE_SCALE};
  endfunction

  assign delta_move = t - last_move_time;
  assign delta_gest = t - last_gesture_time;
  assign touch      = t - last_down_time;
  assign touch_long = !touch[31] && touch[30:0] > {15'd0, shrink_period_ms};
  assign period_eff = (shrink_period_ms == 16'd0) ? 16'd1 : shrink_period_ms;
  assign mag_dx     = abs_diff(last_move_x, x);
  assign mag_dy     = abs_diff(last_move_y, y);
  assign gest_near  = abs_diff(last_gesture_x, x) < {4'd0, tap_radius} &&
                      abs_diff(last_gesture_y, y) < {4'd0, tap_radius};
  assign same_pos   = x == last_move_x && y == last_move_y;
  assign move_rate_hit = rate_hit(delta_move);
  assign gest_rate_hit = rate_hit(delta_gest);
  assign delta_sel  = (op == pet_pkg::OP_MOVE) ? delta_move : delta_gest;
  assign rate_lim   = (op == pet_pkg::OP_MOVE) ? ({1'b0, max_move_rate_hz} + 11'd1)
                                               : ({1'b0, max_gesture_rate_hz} + 11'd1);
  assign rad_diff   = tap_radius - div_rsp.quo[11:0];
  assign radius_shrunk = (div_rsp.quo >= {{(NumW-12){1'b0}}, tap_radius} ||
                          rad_diff < tap_radius_min) ? tap_radius_min : rad_diff;
  assign dist_sq    = {1'b0, dx_sq} + {1'b0, mul_p[31:0]};
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_RATE: begin
        mul_a = {22'd0, delta_sel[9:0]};
        mul_b = {21'd0, rate_lim};
      end
      S_RP: begin
        mul_a = {20'd0, tap_radius};
        mul_b = {25'd0, shrink_percent};
      end
      S_NUM: begin
        mul_a = {13'd0, mul_p[18:0]};
        mul_b = {1'b0, touch[30:0]};
      end
      S_DEN: begin
        mul_a = {16'd0, period_eff};
        mul_b = {25'd0, pet_pkg::PERCENT_SCALE};
      end
      S_R2: begin
        mul_a = {20'd0, radius};
        mul_b = {20'd0, radius};
      end
      S_DX: begin
        mul_a = {16'd0, mag_dx};
        mul_b = {16'd0, mag_dx};
      end
      S_DY: begin
        mul_a = {16'd0, mag_dy};
        mul_b = {16'd0, mag_dy};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_req.start = state == S_DIVGO;
  assign div_req.num   = num;
  assign div_req.den   = mul_p[pet_pkg::DenW-1:0];

  pet_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  pet_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_radius          <= 12'd10;
      tap_radius_min      <= 12'd2;
      shrink_period_ms    <= 16'd100;
      shrink_percent      <= 7'd10;
      max_move_rate_hz    <= 10'd60;
      max_gesture_rate_hz <= 10'd60;
    end else if (cfg_valid) begin
      case (cfg_index)
        pet_pkg::REG_TAP_RADIUS:     tap_radius          <= cfg_data[11:0];
        pet_pkg::REG_TAP_RADIUS_MIN: tap_radius_min      <= cfg_data[11:0];
        pet_pkg::REG_SHRINK_PERIOD:  shrink_period_ms    <= cfg_data;
        pet_pkg::REG_SHRINK_PERCENT: shrink_percent      <= cfg_data[6:0];
        pet_pkg::REG_MAX_MOVE_RATE:  max_move_rate_hz    <= cfg_data[9:0];
        pet_pkg::REG_MAX_GEST_RATE:  max_gesture_rate_hz <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      m_tvalid          <= 1'b0;
      tap_tracking      <= 1'b0;
      last_move_x       <= 16'hFFFF;
      last_move_y       <= 16'hFFFF;
      last_move_time    <= '0;
      last_down_time    <= '0;
      last_gesture_x    <= 16'hFFFF;
      last_gesture_y    <= 16'hFFFF;
      last_gesture_time <= '0;
    end else begin
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          case (op)
            pet_pkg::OP_MOVE: begin
              if (tap_tracking) begin
                state <= touch_long ? S_RP : S_R2;
              end else if (same_pos) begin
                state <= S_OUT;
              end else begin
                state <= move_rate_hit ? S_RATE : S_OUT;
              end
            end
            pet_pkg::OP_GESTURE: begin
              state <= gest_rate_hit ? S_RATE : S_OUT;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_RATE:  state <= S_RCMP;
        S_RCMP:  state <= S_OUT;
        S_RP:    state <= S_NUM;
        S_NUM:   state <= S_DEN;
        S_DEN:   state <= S_DIVGO;
        S_DIVGO: state <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_R2;
          end
        end
        S_R2:    state <= S_DX;
        S_DX:    state <= S_DY;
        S_DY:    state <= S_CMP;
        S_CMP:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
            case (op)
              pet_pkg::OP_DOWN: begin
                last_move_x    <= x;
                last_move_y    <= y;
                last_down_time <= t;
                last_move_time <= t;
                tap_tracking   <= 1'b1;
              end
              pet_pkg::OP_UP: begin
                last_move_x    <= '0;
                last_move_y    <= '0;
                last_down_time <= '0;
                last_move_time <= '0;
                tap_tracking   <= 1'b0;
              end
              pet_pkg::OP_MOVE: begin
                if (!drop) begin
                  last_move_x    <= x;
                  last_move_y    <= y;
                  last_move_time <= t;
                  tap_tracking   <= 1'b0;
                end
              end
              pet_pkg::OP_GESTURE: begin
                if (!drop) begin
                  last_gesture_x    <= x;
                  last_gesture_y    <= y;
                  last_gesture_time <= t;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op <= s_tuser;
          x  <= s_tdata[15:0];
          y  <= s_tdata[31:16];
          t  <= s_tdata[63:32];
        end
      end
      S_DEC: begin
        radius <= tap_radius;
        if (op == pet_pkg::OP_MOVE) begin
          drop <= same_pos;
        end else if (op == pet_pkg::OP_GESTURE) begin
          drop <= gest_near;
        end else begin
          drop <= 1'b0;
        end
      end
      S_RCMP: begin
        drop <= mul_p <= {54'd0, pet_pkg::RATE_SCALE} ||
                (op == pet_pkg::OP_GESTURE && gest_near);
      end
      S_DEN: num <= mul_p[NumW-1:0];
      S_DIV: begin
        if (div_rsp.done) begin
          radius <= radius_shrunk;
        end
      end
      S_DX:  radius_sq <= mul_p[23:0];
      S_DY:  dx_sq <= mul_p[31:0];
      S_CMP: drop <= dist_sq < {9'd0, radius_sq};
      S_OUT: begin
        if (out_free) begin
          out_drop <= drop;
          if (op == pet_pkg::OP_UP && tap_tracking) begin
            out_x <= last_move_x;
            out_y <= last_move_y;
          end else begin
            out_x <= x;
            out_y <= y;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign s_tready = state == S_IDLE;
  assign m_tdata  = {out_y, out_x};
  assign m_tuser  = out_drop;

endmodule

FILE: hdl/pet_checker.sv
module pet_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second event accepted while one is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed before transfer");

endmodule

bind pen_event_throttle_core pet_checker u_pet_checker (.*);

FILE: bench/tb_top.sv
module tb_top;

  localparam int OpW = pet_pkg::OpW;
  localparam int CoordW = pet_pkg::CoordW;
  localparam int TimeW = pet_pkg::TimeW;
  localparam int CfgIdxW = pet_pkg::CfgIdxW;
  localparam int CfgDataW = pet_pkg::CfgDataW;
  localparam int IdleLimit = 4000;
  localparam int NumPhases = 7;
  localparam int EventsPerPhase = 100;
  localparam int MaxReports = 10;
  localparam logic [OpW-1:0] OP_OTHER = 3'd4;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [TimeW-1:0]  t;
  } pen_event_t;

  typedef struct packed {
    logic              drop;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } verdict_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pen_event_throttle_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  pen_event_t event_queue[$];
  verdict_t   expected_verdicts[$];
  reg_write_t reg_writes[$];
  pen_event_t on_bus;
  reg_write_t next_write;
  verdict_t   want;

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned tx_gap;
  int unsigned rx_stall;
  int unsigned quiet;
  int unsigned now_ms;
  int          phase_events;
  int          accepted_events;
  int          results;
  int          drops;
  int          cfg_writes;
  int          errors;

  // Shadow of the throttle registers and pen state.
  int unsigned radius_cfg, radius_min_cfg, period_cfg, percent_cfg;
  int unsigned move_rate_cfg, gest_rate_cfg;
  bit          tracking;
  shortint     mv_x, mv_y, gs_x, gs_y;
  int unsigned mv_time, down_time, gs_time;

  function automatic void reset_pen_state();
    tracking = 1'b0;
    mv_x = -1;
    mv_y = -1;
    mv_time = 0;
    down_time = 0;
    gs_x = -1;
    gs_y = -1;
    gs_time = 0;
  endfunction

  function automatic longint rate_hz(int unsigned now, int unsigned prev);
    int d;
    d = now - prev;
    return (d != 0) ? longint'(pet_pkg::RATE_SCALE) / longint'(d) : 0;
  endfunction

  function automatic verdict_t judge_event(pen_event_t ev);
    verdict_t v;
    longint   x, y, hz, touch, rad, per, dx, dy;
    int       d;
    x = longint'($signed(ev.x));
    y = longint'($signed(ev.y));
    v.drop = 1'b0;
    v.x = ev.x;
    v.y = ev.y;
    case (ev.op)
      pet_pkg::OP_DOWN: begin
        mv_x = ev.x;
        mv_y = ev.y;
        down_time = ev.t;
        mv_time = ev.t;
        tracking = 1'b1;
      end
      pet_pkg::OP_UP: begin
        if (tracking) begin
          v.x = mv_x;
          v.y = mv_y;
        end
        mv_x = 0;
        mv_y = 0;
        down_time = 0;
        mv_time = 0;
        tracking = 1'b0;
      end
      pet_pkg::OP_MOVE: begin
        hz = rate_hz(ev.t, mv_time);
        if (tracking) begin
          d = ev.t - down_time;
          touch = d;
          rad = longint'(radius_cfg);
          if (touch > longint'(period_cfg)) begin
            per = (period_cfg == 0) ? 1 : longint'(period_cfg);
            rad = rad - (rad * longint'(percent_cfg) * touch)
                        / (per * longint'(pet_pkg::PERCENT_SCALE));
            if (rad < longint'(radius_min_cfg)) begin
              rad = longint'(radius_min_cfg);
            end
          end
          dx = longint'(mv_x) - x;
          dy = longint'(mv_y) - y;
          if (dx * dx + dy * dy < rad * rad) begin
            v.drop = 1'b1;
          end else begin
            tracking = 1'b0;
          end
        end else if (x == longint'(mv_x) && y == longint'(mv_y)) begin
          v.drop = 1'b1;
        end else if (hz > longint'(move_rate_cfg)) begin
          v.drop = 1'b1;
        end
        if (!v.drop) begin
          mv_x = ev.x;
          mv_y = ev.y;
          mv_time = ev.t;
        end
      end
      pet_pkg::OP_GESTURE: begin
        hz = rate_hz(ev.t, gs_time);
        dx = longint'(gs_x) - x;
        dy = longint'(gs_y) - y;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (hz > longint'(gest_rate_cfg) ||
            (dx < longint'(radius_cfg) && dy < longint'(radius_cfg))) begin
          v.drop = 1'b1;
        end else begin
          gs_x = ev.x;
          gs_y = ev.y;
          gs_time = ev.t;
        end
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [15:0] jitter();
    int unsigned r;
    int          j;
    r = $urandom_range(0, 9);
    if (r < 6) j = int'($urandom_range(0, 24)) - 12;
    else if (r < 9) j = int'($urandom_range(0, 200)) - 100;
    else j = $urandom;
    return j[15:0];
  endfunction

  function automatic int unsigned pick_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 20);
    if (r < 80) return $urandom_range(15, 300);
    if (r < 95) return $urandom_range(300, 5000);
    return $urandom;
  endfunction

  task automatic push_event(input logic [OpW-1:0] op, input logic [15:0] x,
                            input logic [15:0] y, input logic [31:0] t);
    pen_event_t ev;
    ev.op = op;
    ev.x = x;
    ev.y = y;
    ev.t = t;
    event_queue.push_back(ev);
    if (op <= pet_pkg::OP_GESTURE) phase_events++;
  endtask

  // Pen down, a few moves or gesture changes around it, and usually a pen up.
  task automatic add_stroke();
    logic [15:0] cx, cy;
    int          n, i;
    cx = 16'($urandom);
    cy = 16'($urandom);
    now_ms += $urandom_range(0, 400);
    push_event(pet_pkg::OP_DOWN, cx, cy, now_ms);
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++) begin
      now_ms += pick_step();
      cx += jitter();
      cy += jitter();
      if ($urandom_range(0, 4) == 0) push_event(pet_pkg::OP_GESTURE, cx, cy, now_ms);
      else push_event(pet_pkg::OP_MOVE, cx, cy, now_ms);
    end
    if ($urandom_range(0, 5) != 0) begin
      now_ms += pick_step();
      push_event(pet_pkg::OP_UP, cx + jitter(), cy + jitter(), now_ms);
    end
  endtask

  task automatic add_noise();
    logic [31:0] t;
    if ($urandom_range(0, 1) == 0) t = now_ms + pick_step();
    else t = $urandom;
    push_event(pet_pkg::OP_DOWN + 3'($urandom_range(0, 7)),
               16'($urandom), 16'($urandom), t);
  endtask

  task automatic load_settings(input int unsigned rad, input int unsigned rmin,
                               input int unsigned per, input int unsigned pct,
                               input int unsigned mrate, input int unsigned grate);
    reg_writes.push_back('{pet_pkg::REG_TAP_RADIUS, CfgDataW'(rad)});
    reg_writes.push_back('{pet_pkg::REG_TAP_RADIUS_MIN, CfgDataW'(rmin)});
    reg_writes.push_back('{pet_pkg::REG_SHRINK_PERIOD, CfgDataW'(per)});
    reg_writes.push_back('{pet_pkg::REG_SHRINK_PERCENT, CfgDataW'(pct)});
    reg_writes.push_back('{pet_pkg::REG_MAX_MOVE_RATE, CfgDataW'(mrate)});
    reg_writes.push_back('{pet_pkg::REG_MAX_GEST_RATE, CfgDataW'(grate)});
    while (reg_writes.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  // The stimulus waits until every queued event is sent and every outstanding result has come back.
  task automatic drain();
    while (event_queue.size() != 0 || s_tvalid || expected_verdicts.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
      reset_pen_state();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_verdicts.push_back(judge_event(on_bus));
        accepted_events++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          s_tvalid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (event_queue.size() != 0) begin
          on_bus = event_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {on_bus.t, on_bus.y, on_bus.x};
          s_tuser <= on_bus.op;
          tx_gap <= tx_idle_on ? pick_gap() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("Unexpected result transfer: drop=%0b x=%0d y=%0d",
                     m_tuser, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
          end
        end else begin
          want = expected_verdicts.pop_front();
          results++;
          if (want.drop) drops++;
          if (m_tuser !== want.drop || m_tdata[15:0] !== want.x ||
              m_tdata[31:16] !== want.y) begin
            errors++;
            if (errors <= MaxReports) begin
              $display("Result %0d differs: expected drop=%0b x=%0d y=%0d, got drop=%0b x=%0d y=%0d",
                       results, want.drop, $signed(want.x), $signed(want.y),
                       m_tuser, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
            end
          end
        end
      end
      if (rx_stall != 0) begin
        m_tready <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else begin
        m_tready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 2) == 0) rx_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
      radius_cfg = 10;
      radius_min_cfg = 2;
      period_cfg = 100;
      percent_cfg = 10;
      move_rate_cfg = 60;
      gest_rate_cfg = 60;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          pet_pkg::REG_TAP_RADIUS:     radius_cfg = cfg_data[11:0];
          pet_pkg::REG_TAP_RADIUS_MIN: radius_min_cfg = cfg_data[11:0];
          pet_pkg::REG_SHRINK_PERIOD:  period_cfg = cfg_data;
          pet_pkg::REG_SHRINK_PERCENT: percent_cfg = cfg_data[6:0];
          pet_pkg::REG_MAX_MOVE_RATE:  move_rate_cfg = cfg_data[9:0];
          pet_pkg::REG_MAX_GEST_RATE:  gest_rate_cfg = cfg_data[9:0];
          default: begin
          end
        endcase
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_writes.size() != 0) begin
          next_write = reg_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_write.idx;
          cfg_data <= next_write.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == IdleLimit) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               IdleLimit, expected_verdicts.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int          phase;
    int unsigned r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_event(OP_OTHER, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
    push_event(pet_pkg::OP_GESTURE, 16'd2, 16'd3, 32'd0);
    push_event(pet_pkg::OP_GESTURE, 16'd100, 16'd100, 32'd1000);
    push_event(pet_pkg::OP_GESTURE, 16'd300, 16'd300, 32'd1005);
    push_event(pet_pkg::OP_MOVE, 16'hFFFF, 16'hFFFF, 32'd2000);
    push_event(pet_pkg::OP_MOVE, 16'd5, 16'd5, 32'd1);
    push_event(pet_pkg::OP_MOVE, 16'd5, 16'd5, 32'd3000);
    push_event(pet_pkg::OP_MOVE, 16'd6, 16'd5, 32'd2990);
    push_event(pet_pkg::OP_DOWN, 16'd0, 16'd0, 32'd10000);
    push_event(pet_pkg::OP_MOVE, 16'd3, 16'd0, 32'd10010);
    push_event(pet_pkg::OP_MOVE, 16'd3, 16'd0, 32'd10500);
    push_event(pet_pkg::OP_MOVE, 16'd1, 16'd1, 32'd20000);
    push_event(pet_pkg::OP_MOVE, 16'd0, 16'd2, 32'd20001);
    push_event(pet_pkg::OP_UP, 16'd9, 16'd9, 32'd20100);
    push_event(pet_pkg::OP_DOWN, 16'd7, 16'd8, 32'd30000);
    push_event(pet_pkg::OP_UP, 16'd100, -16'sd100, 32'd30010);
    push_event(pet_pkg::OP_DOWN, 16'h8000, 16'h8000, 32'd40000);
    push_event(pet_pkg::OP_MOVE, 16'h7FFF, 16'h7FFF, 32'd40001);
    push_event(pet_pkg::OP_UP, 16'h8000, 16'h7FFF, 32'd40002);
    push_event(pet_pkg::OP_DOWN, 16'd0, 16'd0, 32'hFFFF_FFF0);
    push_event(pet_pkg::OP_MOVE, 16'd1, 16'd0, 32'h0000_0100);
    push_event(pet_pkg::OP_UP, 16'd50, 16'd50, 32'h0000_0200);
    push_event(3'd5, 16'($urandom), 16'($urandom), $urandom);
    push_event(3'd6, 16'($urandom), 16'($urandom), $urandom);
    push_event(3'd7, 16'($urandom), 16'($urandom), $urandom);
    push_event(pet_pkg::OP_GESTURE, 16'h7FFF, 16'h8000, 32'h8000_0000);
    drain();

    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: load_settings(0, 0, 0, 0, 0, 0);
        1: load_settings(4095, 4095, 65535, 100, 1000, 1000);
        2: load_settings(10, 2, 100, 10, 60, 60);
        default: begin
          r = $urandom_range(1, 80);
          load_settings(r, $urandom_range(0, r),
                        ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 600),
                        $urandom_range(0, 100), $urandom_range(0, 1000),
                        $urandom_range(0, 1000));
        end
      endcase
      tx_idle_on = (phase % 3) != 0;
      rx_idle_on = (phase % 3) != 1;
      phase_events = 0;
      now_ms = $urandom;
      while (phase_events < EventsPerPhase) begin
        if ($urandom_range(0, 9) < 8) add_stroke();
        else add_noise();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Run covered %0d pointer events and %0d results (%0d dropped)",
             accepted_events, results, drops);
    $display("across %0d register settings with %0d register writes.",
             NumPhases + 1, cfg_writes);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
